// File: hdl/bfsie_pkg.sv
// ----------------------------------------------------------------------------
// bfsie_pkg
// Shared types and constants for the bit field store insert/extract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsie_pkg;

    localparam int CMD_W         = 2;
    localparam int VALUE_W       = 32;
    localparam int OFFSET_W      = 10;
    localparam int WIDTH_W       = 6;
    localparam int READ_W        = 32;
    localparam int FILL_W        = 11;
    localparam int STATUS_W      = 2;
    localparam int BYTE_BITS     = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_SET    = 2'd1,
        CMD_GET    = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_WIDTH = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] offset;
        logic [WIDTH_W-1:0]  width;
    } t_in_word;

    typedef struct packed {
        logic [READ_W-1:0] read_value;
        logic [FILL_W-1:0] fill_bits;
        t_status           status;
    } t_out_word;

    // decoded command, stage 1 to merge stage
    typedef struct packed {
        logic    wr;
        logic    get;
        logic    odd_first;
        t_status status;
    } t_ctl;

endpackage

`default_nettype wire

// File: hdl/bit_field_store_insert_extract_unit.sv
// ----------------------------------------------------------------------------
// bit_field_store_insert_extract_unit
// MSB-first bit store with append, set-at-offset and get-at-offset commands.
//
// Channel  Direction  Handshake          Word
// in       input      i_valid / o_stall  bfsie_pkg::t_in_word
// out      output     o_valid / i_stall  bfsie_pkg::t_out_word
//
// One word per cycle sustained while the output is not stalled; an accepted
// word waits in stage 1; the result register loads it when free and sets o_valid.
// The store is two row banks (even/odd rows), each one read and one write
// per cycle; a field always sits in one even and one odd row.
// After reset a clearing pass writes zero to all BD = ROWS/2 + 2 rows of both
// banks; o_stall is high meanwhile.
// A stalled result holds in the output register; one more word waits in
// stage 1, then o_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_field_store_insert_extract_unit #(
    parameter int STORE_BITS = 1024,
    parameter int MAX_WIDTH  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  bfsie_pkg::t_in_word  i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output bfsie_pkg::t_out_word o_word
);

    localparam int FW    = $clog2(STORE_BITS + 1);
    localparam int ROW_W = (MAX_WIDTH > bfsie_pkg::BYTE_BITS) ?
                           2 ** $clog2(MAX_WIDTH) : bfsie_pkg::BYTE_BITS;
    localparam int LSB_W = $clog2(ROW_W) + 1;
    localparam int ROWS  = (STORE_BITS + ROW_W - 1) / ROW_W;
    localparam int BD    = ROWS / 2 + 2;
    localparam int BA    = $clog2(BD);

    logic          r_s1_v;
    logic          n_s1_v;
    logic          r_out_v;
    logic          n_out_v;
    logic          r_clr_busy;
    logic [BA-1:0] r_clr_addr;

    logic take;
    logic adv;

    logic [BA-1:0]                 ev_raddr;
    logic [BA-1:0]                 od_raddr;
    logic [BA-1:0]                 ev_addr;
    logic [BA-1:0]                 od_addr;
    bfsie_pkg::t_ctl               ctl;
    logic [LSB_W-1:0]              lsb;
    logic [bfsie_pkg::WIDTH_W-1:0] width_q;
    logic [bfsie_pkg::VALUE_W-1:0] value_q;
    logic [FW-1:0]                 fill_q;
    logic [ROW_W-1:0]              ev_rdata;
    logic [ROW_W-1:0]              od_rdata;
    logic                          dp_we;
    logic [ROW_W-1:0]              ev_wdata;
    logic [ROW_W-1:0]              od_wdata;

    logic             ram_we;
    logic [BA-1:0]    ev_waddr;
    logic [BA-1:0]    od_waddr;
    logic [ROW_W-1:0] ev_wd;
    logic [ROW_W-1:0] od_wd;

    assign adv     = r_s1_v && (!r_out_v || !i_stall);
    assign o_stall = r_clr_busy || (r_s1_v && !adv);
    assign take    = i_valid && !o_stall;
    assign o_valid = r_out_v;

    assign n_s1_v  = take ? 1'b1 : (adv ? 1'b0 : r_s1_v);
    assign n_out_v = adv ? 1'b1 : (i_stall ? r_out_v : 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_s1_v  <= n_s1_v;
            r_out_v <= n_out_v;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + BA'(1);
                if (r_clr_addr == BA'(BD - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    bfsie_decode #(
        .STORE_BITS (STORE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_word     (i_word),
        .o_ev_raddr (ev_raddr),
        .o_od_raddr (od_raddr),
        .o_ev_addr  (ev_addr),
        .o_od_addr  (od_addr),
        .o_ctl      (ctl),
        .o_lsb      (lsb),
        .o_width    (width_q),
        .o_value    (value_q),
        .o_fill     (fill_q)
    );

    bfsie_datapath #(
        .STORE_BITS (STORE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_ctl      (ctl),
        .i_ev_addr  (ev_addr),
        .i_od_addr  (od_addr),
        .i_lsb      (lsb),
        .i_width    (width_q),
        .i_value    (value_q),
        .i_fill     (fill_q),
        .i_ev_rdata (ev_rdata),
        .i_od_rdata (od_rdata),
        .o_we       (dp_we),
        .o_ev_wdata (ev_wdata),
        .o_od_wdata (od_wdata),
        .o_word     (o_word)
    );

    // clearing pass owns the write ports until done
    assign ram_we   = r_clr_busy || dp_we;
    assign ev_waddr = r_clr_busy ? r_clr_addr : ev_addr;
    assign od_waddr = r_clr_busy ? r_clr_addr : od_addr;
    assign ev_wd    = r_clr_busy ? '0 : ev_wdata;
    assign od_wd    = r_clr_busy ? '0 : od_wdata;

    bfsie_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BD)
    ) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ev_waddr),
        .i_wdata (ev_wd),
        .i_re    (take),
        .i_raddr (ev_raddr),
        .o_rdata (ev_rdata)
    );

    bfsie_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BD)
    ) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (od_waddr),
        .i_wdata (od_wd),
        .i_re    (take),
        .i_raddr (od_raddr),
        .o_rdata (od_rdata)
    );

`ifndef ASSERT_OFF
    a_no_item_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !dp_we)
        else $error("item write during clearing pass");

    a_err_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.status != bfsie_pkg::ST_OK) |-> (o_word.read_value == '0))
        else $error("nonzero read value with error status");

    a_take_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_s1_v)
        else $error("accepted word lost before stage 1");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_valid)
        else $error("advanced word lost before output");

    a_write_only_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_we |-> (r_s1_v && ctl.wr && !ctl.get))
        else $error("store write without a valid set or append");
`endif

endmodule

`default_nettype wire

// File: hdl/bfsie_ram.sv
// ----------------------------------------------------------------------------
// bfsie_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsie_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/bfsie_decode.sv
// ----------------------------------------------------------------------------
// bfsie_decode
// Command decode, bounds checks, fill register and stage 1 register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsie_decode #(
    parameter int  STORE_BITS = 1024,
    parameter int  MAX_WIDTH  = 32,
    localparam int FW    = $clog2(STORE_BITS + 1),
    localparam int ROW_W = (MAX_WIDTH > bfsie_pkg::BYTE_BITS) ?
                           2 ** $clog2(MAX_WIDTH) : bfsie_pkg::BYTE_BITS,
    localparam int RWL   = $clog2(ROW_W),
    localparam int SUM_W = ((FW > bfsie_pkg::OFFSET_W) ? FW : bfsie_pkg::OFFSET_W) + 1,
    localparam int RAW   = SUM_W - RWL,
    localparam int ROWS  = (STORE_BITS + ROW_W - 1) / ROW_W,
    localparam int BD    = ROWS / 2 + 2,
    localparam int BA    = $clog2(BD),
    localparam int LSB_W = RWL + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_take,
    input  bfsie_pkg::t_in_word              i_word,
    output logic [BA-1:0]                    o_ev_raddr,
    output logic [BA-1:0]                    o_od_raddr,
    output logic [BA-1:0]                    o_ev_addr,
    output logic [BA-1:0]                    o_od_addr,
    output bfsie_pkg::t_ctl                  o_ctl,
    output logic [LSB_W-1:0]                 o_lsb,
    output logic [bfsie_pkg::WIDTH_W-1:0]    o_width,
    output logic [bfsie_pkg::VALUE_W-1:0]    o_value,
    output logic [FW-1:0]                    o_fill
);

    localparam int MW_W = bfsie_pkg::WIDTH_W + 1;

    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;
    logic [BA-1:0]    r_ev_addr;
    logic [BA-1:0]    r_od_addr;
    bfsie_pkg::t_ctl  r_ctl;
    bfsie_pkg::t_ctl  n_ctl;
    logic [LSB_W-1:0] r_lsb;
    logic [LSB_W-1:0] n_lsb;
    logic [bfsie_pkg::WIDTH_W-1:0] r_width;
    logic [bfsie_pkg::VALUE_W-1:0] r_value;

    logic [SUM_W-1:0] start_pos;
    logic [SUM_W-1:0] end_pos;
    logic [RAW-1:0]   row;
    logic [RAW:0]     row_inc;
    logic [RWL-1:0]   bit_in_row;
    logic             noop;
    logic             too_wide;
    logic             over_store;
    logic             over_fill;

    assign start_pos  = (i_word.cmd == bfsie_pkg::CMD_APPEND) ? SUM_W'(r_fill)
                                                               : SUM_W'(i_word.offset);
    assign end_pos    = start_pos + SUM_W'(i_word.width);
    assign row        = start_pos[SUM_W-1:RWL];
    assign row_inc    = (RAW+1)'(row) + (RAW+1)'(1);
    assign bit_in_row = start_pos[RWL-1:0];

    assign noop       = (i_word.width == '0) || (i_word.cmd == bfsie_pkg::CMD_NONE);
    assign too_wide   = MW_W'(i_word.width) > MW_W'(MAX_WIDTH);
    assign over_store = end_pos > SUM_W'(STORE_BITS);
    assign over_fill  = end_pos > SUM_W'(r_fill);

    // even bank holds rows 0,2,4..; the window is rows r and r+1
    assign o_ev_raddr = BA'(row_inc >> 1);
    assign o_od_raddr = BA'(row >> 1);

    always_comb begin
        n_ctl.wr        = 1'b0;
        n_ctl.get       = 1'b0;
        n_ctl.odd_first = row[0];
        n_ctl.status    = bfsie_pkg::ST_OK;
        n_fill          = r_fill;
        if (noop) begin
            n_ctl.status = bfsie_pkg::ST_OK;
        end else if (too_wide) begin
            n_ctl.status = bfsie_pkg::ST_WIDTH;
        end else if (i_word.cmd == bfsie_pkg::CMD_GET) begin
            if (over_fill) begin
                n_ctl.status = bfsie_pkg::ST_RANGE;
            end else begin
                n_ctl.get = 1'b1;
            end
        end else if (over_store) begin
            n_ctl.status = bfsie_pkg::ST_RANGE;
        end else begin
            n_ctl.wr = 1'b1;
            if (i_word.cmd == bfsie_pkg::CMD_APPEND || over_fill) begin
                n_fill = FW'(end_pos);
            end
        end
    end

    // window bit index of the field LSB: 2*ROW_W - bit_in_row - width, mod 2*ROW_W
    assign n_lsb = LSB_W'(0) - LSB_W'(bit_in_row) - LSB_W'(i_word.width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_take) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_ev_addr <= o_ev_raddr;
            r_od_addr <= o_od_raddr;
            r_ctl     <= n_ctl;
            r_lsb     <= n_lsb;
            r_width   <= i_word.width;
            r_value   <= i_word.value;
        end
    end

    assign o_ev_addr = r_ev_addr;
    assign o_od_addr = r_od_addr;
    assign o_ctl     = r_ctl;
    assign o_lsb     = r_lsb;
    assign o_width   = r_width;
    assign o_value   = r_value;
    assign o_fill    = r_fill;

endmodule

`default_nettype wire

// File: hdl/bfsie_datapath.sv
// ----------------------------------------------------------------------------
// bfsie_datapath
// Two-row window merge and extract, write forwarding and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsie_datapath #(
    parameter int  STORE_BITS = 1024,
    parameter int  MAX_WIDTH  = 32,
    localparam int FW    = $clog2(STORE_BITS + 1),
    localparam int ROW_W = (MAX_WIDTH > bfsie_pkg::BYTE_BITS) ?
                           2 ** $clog2(MAX_WIDTH) : bfsie_pkg::BYTE_BITS,
    localparam int RWL   = $clog2(ROW_W),
    localparam int ROWS  = (STORE_BITS + ROW_W - 1) / ROW_W,
    localparam int BD    = ROWS / 2 + 2,
    localparam int BA    = $clog2(BD),
    localparam int LSB_W = RWL + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  bfsie_pkg::t_ctl               i_ctl,
    input  logic [BA-1:0]                 i_ev_addr,
    input  logic [BA-1:0]                 i_od_addr,
    input  logic [LSB_W-1:0]              i_lsb,
    input  logic [bfsie_pkg::WIDTH_W-1:0] i_width,
    input  logic [bfsie_pkg::VALUE_W-1:0] i_value,
    input  logic [FW-1:0]                 i_fill,
    input  logic [ROW_W-1:0]              i_ev_rdata,
    input  logic [ROW_W-1:0]              i_od_rdata,
    output logic                          o_we,
    output logic [ROW_W-1:0]              o_ev_wdata,
    output logic [ROW_W-1:0]              o_od_wdata,
    output bfsie_pkg::t_out_word          o_word
);

    localparam int WIN_W = 2 * ROW_W;
    localparam int EXT_W = (WIN_W > bfsie_pkg::READ_W) ? WIN_W : bfsie_pkg::READ_W;

    logic                 r_fwd_v;
    logic [BA-1:0]        r_fwd_ev_addr;
    logic [BA-1:0]        r_fwd_od_addr;
    logic [ROW_W-1:0]     r_fwd_ev;
    logic [ROW_W-1:0]     r_fwd_od;
    bfsie_pkg::t_out_word r_word;
    bfsie_pkg::t_out_word n_word;

    logic [ROW_W-1:0] ev_cur;
    logic [ROW_W-1:0] od_cur;
    logic [WIN_W-1:0] win;
    logic [WIN_W-1:0] ins_mask;
    logic [WIN_W-1:0] ins_data;
    logic [WIN_W-1:0] new_win;
    logic [EXT_W-1:0] mask_ext;
    logic [EXT_W-1:0] field_ext;

    // the last write lands on the same edge as the next read, so bypass it
    assign ev_cur = (r_fwd_v && r_fwd_ev_addr == i_ev_addr) ? r_fwd_ev : i_ev_rdata;
    assign od_cur = (r_fwd_v && r_fwd_od_addr == i_od_addr) ? r_fwd_od : i_od_rdata;

    assign win       = i_ctl.odd_first ? {od_cur, ev_cur} : {ev_cur, od_cur};
    assign mask_ext  = ~({EXT_W{1'b1}} << i_width);
    assign ins_mask  = WIN_W'(mask_ext << i_lsb);
    assign ins_data  = WIN_W'((EXT_W'(i_value) & mask_ext) << i_lsb);
    assign new_win   = (win & ~ins_mask) | ins_data;
    assign field_ext = (EXT_W'(win) >> i_lsb) & mask_ext;

    assign o_we       = i_adv && i_ctl.wr;
    assign o_ev_wdata = i_ctl.odd_first ? new_win[ROW_W-1:0] : new_win[WIN_W-1:ROW_W];
    assign o_od_wdata = i_ctl.odd_first ? new_win[WIN_W-1:ROW_W] : new_win[ROW_W-1:0];

    always_comb begin
        n_word.read_value = i_ctl.get ? field_ext[bfsie_pkg::READ_W-1:0] : '0;
        n_word.fill_bits  = bfsie_pkg::FILL_W'(i_fill);
        n_word.status     = i_ctl.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (o_we) begin
            r_fwd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_fwd_ev_addr <= i_ev_addr;
            r_fwd_od_addr <= i_od_addr;
            r_fwd_ev      <= o_ev_wdata;
            r_fwd_od      <= o_od_wdata;
        end
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire
